### rtl/shnp_pkg.sv
package shnp_pkg;

  localparam int MAX_PARTICLES = 4096;
  localparam int IDX_W         = $clog2(MAX_PARTICLES);
  localparam int PTR_W         = IDX_W + 1;
  localparam int GRID_BITS     = 6;
  localparam int GRID_ROOT     = 1 << GRID_BITS;
  localparam int CELL_W        = 3 * GRID_BITS;
  localparam int CELLS         = 1 << CELL_W;
  localparam int MAX_PAIRS     = 64;
  localparam int PAIR_CNT_W    = $clog2(MAX_PAIRS + 1);
  localparam int POS_W         = 24;
  localparam int CFG_W         = 23;
  localparam int CFG_IDX_W     = 1;
  localparam int Q_W           = 26;
  localparam int R2_W          = 2 * CFG_W;
  localparam int PROD_W        = 2 * (POS_W + 1);
  localparam int ACC_W         = PROD_W + 2;

  localparam logic [PTR_W-1:0] NIL = '1;

  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 1'd1;

  typedef enum logic [1:0] {DIV_POS, DIV_LO, DIV_HI} div_mode_t;
  typedef enum logic [2:0] {EMIT_NONE, EMIT_MID, EMIT_LAST, EMIT_TRUNC, EMIT_EMPTY} emit_t;

  typedef struct packed {
    logic      clr_start;
    logic      clr_step;
    logic      take_in;
    logic      div_start;
    div_mode_t div_mode;
    logic [1:0] axis;
    logic      box_init;
    logic      box_step;
    logic      ins_link;
    logic      ins_fin;
    logic      rd_key;
    logic      load_p;
    logic      load_head;
    logic      load_next;
    logic      sq;
    logic      acc_clr;
    logic      acc_add;
    logic      hit_take;
    emit_t     emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic ins_ok;
    logic key_known;
    logic box_last;
    logic other_nil;
    logic other_gt;
    logic hit;
    logic n_full;
    logic pend_v;
    logic out_free;
  } status_t;

endpackage

### rtl/shnp_item_if.sv
interface shnp_item_if import shnp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              operation;
  logic [IDX_W-1:0]        particle_index;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;

  modport source (output valid, operation, particle_index, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, operation, particle_index, pos_x, pos_y, pos_z, output ready);
endinterface

### rtl/shnp_pair_if.sv
interface shnp_pair_if import shnp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             pair_found;
  logic [IDX_W-1:0] first_index;
  logic [IDX_W-1:0] second_index;
  logic             last;
  logic             truncated;

  modport source (output valid, pair_found, first_index, second_index, last, truncated,
                  input ready);
  modport sink (input valid, pair_found, first_index, second_index, last, truncated,
                output ready);
endinterface

### rtl/shnp_cfg_if.sv
interface shnp_cfg_if import shnp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/shnp_ram.sv
module shnp_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/shnp_div.sv
// Floor division, one quotient bit per cycle (restoring).
module shnp_div import shnp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [Q_W-1:0] dividend,
  input  logic [CFG_W-1:0]      divisor,
  output logic                  done,
  output logic signed [Q_W-1:0] quot
);
  localparam int MAG_W = Q_W - 1;

  logic             busy;
  logic             neg;
  logic [MAG_W-1:0] mag;
  logic [CFG_W-1:0] rem;
  logic [4:0]       cnt;
  logic [CFG_W:0]   trial;
  logic             ge;
  logic [Q_W-1:0]   abs_a;

  assign abs_a = dividend[Q_W-1] ? Q_W'(-dividend) : dividend;
  assign trial = {rem, mag[MAG_W-1]};
  assign ge    = trial >= {1'b0, divisor};

  // mag holds the quotient after the last shift
  assign quot = neg ? -($signed({1'b0, mag}) + $signed(Q_W'(rem != '0)))
                    : $signed({1'b0, mag});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= dividend[Q_W-1];
        mag  <= abs_a[MAG_W-1:0];
        rem  <= '0;
      end else if (busy) begin
        rem <= ge ? CFG_W'(trial - {1'b0, divisor}) : trial[CFG_W-1:0];
        mag <= {mag[MAG_W-2:0], ge};
        cnt <= cnt + 5'd1;
        if (cnt == 5'(MAG_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### rtl/shnp_datapath.sv
module shnp_datapath import shnp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output status_t                 st,
  input  logic [IDX_W-1:0]        particle_index,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic                    out_pair_found,
  output logic [IDX_W-1:0]        out_first,
  output logic [IDX_W-1:0]        out_second,
  output logic                    out_last,
  output logic                    out_truncated
);
  logic [CFG_W-1:0]        cell_size, radius, divisor;
  logic [R2_W-1:0]         r2;
  logic [IDX_W-1:0]        key;
  logic signed [POS_W-1:0] p [3];
  logic signed [Q_W-1:0]   lo [3], hi [3], c [3];
  logic [PTR_W-1:0]        other, count;
  logic [PAIR_CNT_W-1:0]   n;
  logic [IDX_W-1:0]        pend;
  logic                    pend_v;
  logic [PROD_W-1:0]       prod;
  logic [ACC_W-1:0]        acc;
  logic [CELL_W-1:0]       clr_addr, cell_addr;

  logic signed [Q_W-1:0]   dividend, quot, span, hi_clamped;
  logic                    div_done;
  logic [3*POS_W-1:0]      pos_rd;
  logic signed [POS_W-1:0] pos_rd_ax;
  logic signed [POS_W:0]   diff;
  logic [POS_W:0]          diff_mag;
  logic [PTR_W-1:0]        head_rd, next_rd;
  logic [IDX_W-1:0]        tail_rd;
  logic                    head_nil;
  logic                    head_we, next_we;
  logic [CELL_W-1:0]       head_waddr;
  logic [PTR_W-1:0]        head_wdata, next_wdata;
  logic [IDX_W-1:0]        next_waddr, pos_raddr;

  assign divisor   = (cell_size == '0) ? CFG_W'(1) : cell_size;
  assign cell_addr = {c[2][GRID_BITS-1:0], c[1][GRID_BITS-1:0], c[0][GRID_BITS-1:0]};

  always_comb begin
    case (cmd.div_mode)
      DIV_LO:  dividend = Q_W'(p[cmd.axis]) - $signed({3'b000, radius});
      DIV_HI:  dividend = Q_W'(p[cmd.axis]) + $signed({3'b000, radius});
      default: dividend = Q_W'(p[cmd.axis]);
    endcase
  end

  shnp_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(dividend),
    .divisor(divisor), .done(div_done), .quot(quot)
  );

  // box clamped to GRID_ROOT cells per axis
  assign span       = quot - lo[cmd.axis];
  assign hi_clamped = (span >= Q_W'(GRID_ROOT)) ? lo[cmd.axis] + Q_W'(GRID_ROOT - 1) : quot;

  // memories
  assign head_nil   = head_rd == NIL;
  assign head_we    = cmd.clr_step || (cmd.ins_link && head_nil);
  assign head_waddr = cmd.clr_step ? clr_addr : cell_addr;
  assign head_wdata = cmd.clr_step ? NIL : {1'b0, key};
  assign next_we    = (cmd.ins_link && !head_nil) || cmd.ins_fin;
  assign next_waddr = cmd.ins_fin ? key : tail_rd;
  assign next_wdata = cmd.ins_fin ? NIL : {1'b0, key};
  assign pos_raddr  = cmd.rd_key ? key : other[IDX_W-1:0];

  shnp_ram #(.W(PTR_W), .D(CELLS)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(cell_addr), .rdata(head_rd)
  );
  shnp_ram #(.W(IDX_W), .D(CELLS)) u_tail (
    .clk(clk), .we(cmd.ins_link), .waddr(cell_addr), .wdata(key),
    .raddr(cell_addr), .rdata(tail_rd)
  );
  shnp_ram #(.W(PTR_W), .D(MAX_PARTICLES)) u_next (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(other[IDX_W-1:0]), .rdata(next_rd)
  );
  shnp_ram #(.W(3*POS_W), .D(MAX_PARTICLES)) u_pos (
    .clk(clk), .we(cmd.ins_link), .waddr(key), .wdata({p[2], p[1], p[0]}),
    .raddr(pos_raddr), .rdata(pos_rd)
  );

  always_comb begin
    case (cmd.axis)
      2'd1:    pos_rd_ax = pos_rd[2*POS_W-1:POS_W];
      2'd2:    pos_rd_ax = pos_rd[3*POS_W-1:2*POS_W];
      default: pos_rd_ax = pos_rd[POS_W-1:0];
    endcase
  end

  assign diff     = (POS_W+1)'(p[cmd.axis]) - (POS_W+1)'(pos_rd_ax);
  assign diff_mag = diff[POS_W] ? (POS_W+1)'(-diff) : diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size <= CFG_W'(512);
      radius    <= CFG_W'(256);
      clr_addr  <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      pend_v    <= 1'b0;
      n         <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_CELL_SIZE: cell_size <= cfg_data;
          REG_RADIUS:    radius    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clr_start) begin
        clr_addr <= '0;
        count    <= '0;
      end else if (cmd.clr_step) begin
        clr_addr <= clr_addr + CELL_W'(1);
      end
      if (cmd.ins_fin) begin
        count <= PTR_W'(key) + PTR_W'(1);
      end
      if (cmd.take_in) begin
        pend_v <= 1'b0;
        n      <= '0;
      end else if (cmd.hit_take) begin
        pend_v <= 1'b1;
        n      <= n + PAIR_CNT_W'(1);
      end
      if (cmd.emit != EMIT_NONE) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      key  <= particle_index;
      p[0] <= pos_x;
      p[1] <= pos_y;
      p[2] <= pos_z;
      r2   <= radius * radius;
    end
    if (cmd.load_p) begin
      p[0] <= pos_rd[POS_W-1:0];
      p[1] <= pos_rd[2*POS_W-1:POS_W];
      p[2] <= pos_rd[3*POS_W-1:2*POS_W];
    end
    if (div_done) begin
      if (cmd.div_mode == DIV_HI) begin
        hi[cmd.axis] <= hi_clamped;
      end else begin
        lo[cmd.axis] <= quot;
      end
    end
    if (cmd.box_init) begin
      c <= lo;
    end else if (cmd.box_step) begin
      if (c[0] != hi[0]) begin
        c[0] <= c[0] + Q_W'(1);
      end else begin
        c[0] <= lo[0];
        if (c[1] != hi[1]) begin
          c[1] <= c[1] + Q_W'(1);
        end else begin
          c[1] <= lo[1];
          c[2] <= c[2] + Q_W'(1);
        end
      end
    end
    if (cmd.load_head) begin
      other <= head_rd;
    end else if (cmd.load_next) begin
      other <= next_rd;
    end
    if (cmd.hit_take) begin
      pend <= other[IDX_W-1:0];
    end
    if (cmd.sq) begin
      prod <= diff_mag * diff_mag;
    end
    if (cmd.acc_clr) begin
      acc <= ACC_W'(prod);
    end else if (cmd.acc_add) begin
      acc <= acc + ACC_W'(prod);
    end
    if (cmd.emit != EMIT_NONE) begin
      out_pair_found <= cmd.emit != EMIT_EMPTY;
      out_first      <= key;
      out_second     <= (cmd.emit == EMIT_EMPTY) ? '0 : pend;
      out_last       <= cmd.emit != EMIT_MID;
      out_truncated  <= cmd.emit == EMIT_TRUNC;
    end
  end

  assign st.clr_last  = clr_addr == '1;
  assign st.div_done  = div_done;
  assign st.ins_ok    = PTR_W'(key) >= count;
  assign st.key_known = PTR_W'(key) < count;
  assign st.box_last  = (c[0] == hi[0]) && (c[1] == hi[1]) && (c[2] == hi[2]);
  assign st.other_nil = other[PTR_W-1];
  assign st.other_gt  = other[IDX_W-1:0] > key;
  assign st.hit       = acc <= ACC_W'(r2);
  assign st.n_full    = n == PAIR_CNT_W'(MAX_PAIRS);
  assign st.pend_v    = pend_v;
  assign st.out_free  = !out_valid || out_ready;
endmodule

### rtl/shnp_ctrl.sv
module shnp_ctrl import shnp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_ready,
  input  status_t    st,
  output cmd_t       cmd
);
  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE,
    S_I_CHK, S_I_DIV, S_I_DWAIT, S_I_BOX, S_I_RD, S_I_LINK, S_I_FIN,
    S_Q_RD, S_Q_LOAD, S_Q_DIV, S_Q_DWAIT, S_Q_BOX, S_Q_CELL, S_Q_HEAD,
    S_Q_WAIT, S_Q_WALK, S_Q_SQX, S_Q_SQY, S_Q_SQZ, S_Q_ACC, S_Q_TEST, S_Q_END
  } state_t;

  state_t     state, state_next;
  logic [1:0] axis, axis_next;
  logic       upper, upper_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      axis  <= '0;
      upper <= 1'b0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      upper <= upper_next;
    end
  end

  always_comb begin
    state_next   = state;
    axis_next    = axis;
    upper_next   = upper;
    cmd          = '0;
    cmd.axis     = axis;
    cmd.div_mode = DIV_POS;
    cmd.emit     = EMIT_NONE;
    in_ready     = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          case (in_op)
            OP_BEGIN: begin
              cmd.clr_start = 1'b1;
              state_next    = S_CLEAR;
            end
            OP_INSERT: state_next = S_I_CHK;
            OP_QUERY:  state_next = S_Q_RD;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_I_CHK: begin
        axis_next  = '0;
        state_next = st.ins_ok ? S_I_DIV : S_IDLE;
      end
      S_I_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = S_I_DWAIT;
      end
      S_I_DWAIT: begin
        if (st.div_done) begin
          if (axis == 2'd2) begin
            state_next = S_I_BOX;
          end else begin
            axis_next  = axis + 2'd1;
            state_next = S_I_DIV;
          end
        end
      end
      S_I_BOX: begin
        cmd.box_init = 1'b1;
        state_next   = S_I_RD;
      end
      S_I_RD:  state_next = S_I_LINK;
      S_I_LINK: begin
        cmd.ins_link = 1'b1;
        state_next   = S_I_FIN;
      end
      S_I_FIN: begin
        cmd.ins_fin = 1'b1;
        state_next  = S_IDLE;
      end
      S_Q_RD: begin
        cmd.rd_key = 1'b1;
        state_next = S_Q_LOAD;
      end
      S_Q_LOAD: begin
        cmd.rd_key = 1'b1;
        cmd.load_p = 1'b1;
        axis_next  = '0;
        upper_next = 1'b0;
        state_next = st.key_known ? S_Q_DIV : S_Q_END;
      end
      S_Q_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_mode  = upper ? DIV_HI : DIV_LO;
        state_next    = S_Q_DWAIT;
      end
      S_Q_DWAIT: begin
        cmd.div_mode = upper ? DIV_HI : DIV_LO;
        if (st.div_done) begin
          if (!upper) begin
            upper_next = 1'b1;
            state_next = S_Q_DIV;
          end else if (axis == 2'd2) begin
            state_next = S_Q_BOX;
          end else begin
            upper_next = 1'b0;
            axis_next  = axis + 2'd1;
            state_next = S_Q_DIV;
          end
        end
      end
      S_Q_BOX: begin
        cmd.box_init = 1'b1;
        state_next   = S_Q_CELL;
      end
      S_Q_CELL: state_next = S_Q_HEAD;
      S_Q_HEAD: begin
        cmd.load_head = 1'b1;
        state_next    = S_Q_WAIT;
      end
      // next and position reads of the new list entry are issued here
      S_Q_WAIT: state_next = S_Q_WALK;
      S_Q_WALK: begin
        if (st.other_nil) begin
          if (st.box_last) begin
            state_next = S_Q_END;
          end else begin
            cmd.box_step = 1'b1;
            state_next   = S_Q_CELL;
          end
        end else if (st.other_gt) begin
          state_next = S_Q_SQX;
        end else begin
          cmd.load_next = 1'b1;
          state_next    = S_Q_WAIT;
        end
      end
      S_Q_SQX: begin
        cmd.sq     = 1'b1;
        cmd.axis   = 2'd0;
        state_next = S_Q_SQY;
      end
      S_Q_SQY: begin
        cmd.sq      = 1'b1;
        cmd.axis    = 2'd1;
        cmd.acc_clr = 1'b1;
        state_next  = S_Q_SQZ;
      end
      S_Q_SQZ: begin
        cmd.sq      = 1'b1;
        cmd.axis    = 2'd2;
        cmd.acc_add = 1'b1;
        state_next  = S_Q_ACC;
      end
      S_Q_ACC: begin
        cmd.acc_add = 1'b1;
        state_next  = S_Q_TEST;
      end
      S_Q_TEST: begin
        if (!st.hit) begin
          cmd.load_next = 1'b1;
          state_next    = S_Q_WAIT;
        end else if (st.n_full) begin
          if (st.out_free) begin
            cmd.emit   = EMIT_TRUNC;
            state_next = S_IDLE;
          end
        end else if (!st.pend_v || st.out_free) begin
          // the held pair goes out once a later one proves it is not last
          if (st.pend_v) cmd.emit = EMIT_MID;
          cmd.hit_take  = 1'b1;
          cmd.load_next = 1'b1;
          state_next    = S_Q_WAIT;
        end
      end
      S_Q_END: begin
        if (st.out_free) begin
          cmd.emit   = st.pend_v ? EMIT_LAST : EMIT_EMPTY;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

### rtl/spatial_hash_neighbor_pairs_core.sv
// Uniform-grid spatial hash for neighbor search over up to 4096 particles in a
// 64x64x64 wrapped cell grid. Begin empties the grid, insert (indices in rising
// order) stores a position and appends it to its cell list, query returns every
// neighbor with a larger index within search_radius, one pair per result, at most
// 64, the final result flagged last (and truncated if pairs were dropped); a query
// with no pair gives one empty result. After reset and after every begin the block
// sweeps the 262144-entry cell head memory, one entry per cycle, and takes no
// request until the sweep is done. An insert is bound by the serial divider that
// finds the cell, run once per axis. A query runs the divider six times for the
// box bounds (low and high per axis), then reads one cell head per cell visited
// and one link per list entry; each entry above the key uses the one shared
// squaring multiplier once per axis. Any output stall also holds the query.
module spatial_hash_neighbor_pairs_core import shnp_pkg::*; (
  input logic         clk,
  input logic         rst,
  shnp_item_if.sink   items,
  shnp_pair_if.source pairs,
  shnp_cfg_if.sink    cfg
);
  cmd_t    cmd;
  status_t st;

  assign cfg.ready = 1'b1;

  shnp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(items.valid), .in_op(items.operation),
    .in_ready(items.ready), .st(st), .cmd(cmd)
  );

  shnp_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .particle_index(items.particle_index),
    .pos_x(items.pos_x), .pos_y(items.pos_y), .pos_z(items.pos_z),
    .cfg_write(cfg.valid && cfg.ready), .cfg_index(cfg.index), .cfg_data(cfg.data),
    .out_ready(pairs.ready), .out_valid(pairs.valid),
    .out_pair_found(pairs.pair_found), .out_first(pairs.first_index),
    .out_second(pairs.second_index), .out_last(pairs.last),
    .out_truncated(pairs.truncated)
  );

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    pairs.valid && pairs.pair_found |-> pairs.second_index > pairs.first_index)
    else $error("pair not ordered");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    pairs.valid && !pairs.pair_found |-> pairs.last && !pairs.truncated)
    else $error("empty result not final");

  a_trunc_last: assert property (@(posedge clk) disable iff (rst)
    pairs.valid && pairs.truncated |-> pairs.last && pairs.pair_found)
    else $error("truncated flag off final pair");

  a_busy_no_take: assert property (@(posedge clk) disable iff (rst)
    pairs.valid && !pairs.last |-> !items.ready)
    else $error("request taken mid query");
endmodule
